FILE: src/date_text_parse_validate_unit_assert.svh
// Assertion macros for the date text parser, clocked on clk and disabled in reset.
`ifndef DATE_TEXT_PARSE_VALIDATE_UNIT_ASSERT_SVH
`define DATE_TEXT_PARSE_VALIDATE_UNIT_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define DTPV_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DTPV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/dtpv_pkg.sv
// Types, constants and the month table shared by the date text parser.
`timescale 1ns / 1ps

package dtpv_pkg;

  localparam logic [30:0] VAL_MAX       = 31'h7FFF_FFFF;
  localparam int          YEAR_MOD      = 400;
  localparam int          CENTURY       = 100;
  localparam int          MONTHS        = 12;
  localparam int          LEAP_FEB_DAYS = 29;
  localparam int          MONTH_FEB     = 2;
  localparam int          HEAD_LEN      = 8;
  localparam int          NUM_FIELDS    = 3;
  localparam logic [7:0]  CHAR_ZERO     = 8'h30;
  localparam logic [7:0]  CHAR_NINE     = 8'h39;
  localparam logic [7:0]  CHAR_DASH     = 8'h2D;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_YMD  = 2'd1,
    FMT_MDY  = 2'd2,
    FMT_DMY  = 2'd3
  } fmt_t;

  // Head pattern flag positions
  localparam int HF_C0_DIGIT = 0;
  localparam int HF_C1_DIGIT = 1;
  localparam int HF_C2_DASH  = 2;
  localparam int HF_C3_DIGIT = 3;
  localparam int HF_C4_DIGIT = 4;
  localparam int HF_C5_DASH  = 5;
  localparam int HF_C4_DASH  = 6;
  localparam int HF_C7_DASH  = 7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic       is_digit;
    logic       is_dash;
    logic [3:0] digit;
    logic       is_last;
  } class_t;

  typedef struct packed {
    logic                   pos_full;
    logic [7:0]             head;
    logic [2:0]             nonempty;
    logic [2:0]             nondig;
    logic [2:0]             ovf;
    logic [2:0][30:0]       vals;
    logic [8:0]             ymod_lead;
    logic [8:0]             ymod_tail;
  } snap_t;

  typedef struct packed {
    logic        date_valid;
    logic [1:0]  format_code;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [30:0] year_out;
  } result_t;

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1:    d = 5'd31;
      4'd2:    d = 5'd28;
      4'd3:    d = 5'd31;
      4'd4:    d = 5'd30;
      4'd5:    d = 5'd31;
      4'd6:    d = 5'd30;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd31;
      4'd9:    d = 5'd30;
      4'd10:   d = 5'd31;
      4'd11:   d = 5'd30;
      4'd12:   d = 5'd31;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: src/date_text_parse_validate_unit.sv
// Date text parser and validator: the top level.
//
// Input queue side: one ASCII character per request on item, with is_last on
// the final character of a string; a request is taken when push is high and
// full is low. Result queue side: one result per string; it is presented while
// empty is low and removed when pop is high.
// Throughput: one character per cycle sustained, including back to back
// strings, while the result queue is not full; the per-character accumulation
// (times ten plus digit, mod 400) is combinational and registered in the back end.
// The result of a string reaches the result ports through the character queue,
// then the snapshot register, then the result queue, once its last character is taken.
// A result waiting to be popped does not hold up the input: the character
// queue, the snapshot register and the result queue let the front and back
// stall independently. With the result queue and snapshot both full, the
// back end stops at the next last character and the input fills once that
// character and MID_DEPTH - 1 more requests are queued.
// Reset (rst, synchronous) empties all queues and clears the accumulators.
`timescale 1ns / 1ps

module date_text_parse_validate_unit #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dtpv_pkg::item_t   item,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output dtpv_pkg::result_t result
);
  import dtpv_pkg::*;

  class_t  cls;
  logic    cls_valid, cls_pop;
  snap_t   snap;
  logic    snap_valid, snap_take;
  result_t res;
  logic    out_full;
  logic [$bits(result_t)-1:0] out_vec;

  dtpv_front #(
    .DEPTH(MID_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cls       (cls),
    .cls_valid (cls_valid),
    .cls_pop   (cls_pop)
  );

  dtpv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cls        (cls),
    .cls_valid  (cls_valid),
    .cls_pop    (cls_pop),
    .snap_take  (snap_take),
    .snap       (snap),
    .snap_valid (snap_valid)
  );

  dtpv_check u_check (
    .snap (snap),
    .res  (res)
  );

  assign snap_take = snap_valid && !out_full;

  dtpv_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (snap_take),
    .wr_data (res),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_vec),
    .empty   (empty)
  );

  assign result = result_t'(out_vec);

`include "date_text_parse_validate_unit_assert.svh"

  `DTPV_ASSERT_ALWAYS(a_invalid_zero,
    empty || result.date_valid ||
    ((result.day_out == '0) && (result.month_out == '0) && (result.year_out == '0)),
    "invalid result carries non-zero date fields")

  `DTPV_ASSERT_ALWAYS(a_valid_has_format,
    empty || !result.date_valid || (result.format_code != FMT_NONE),
    "valid result with unsupported format")

  `DTPV_ASSERT_NEXT(a_snap_holds,
    snap_valid && out_full,
    snap_valid && $stable(snap),
    "pending snapshot lost while result queue full")

endmodule

FILE: src/dtpv_fifo.sv
// Small register queue with full and empty flags.
`timescale 1ns / 1ps

module dtpv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count, count_next;
  logic             do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_comb begin
    case ({do_wr, do_rd})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

FILE: src/dtpv_front.sv
// Front end: takes characters, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module dtpv_front #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dtpv_pkg::item_t item,
  output logic            full,
  output dtpv_pkg::class_t cls,
  output logic            cls_valid,
  input  logic            cls_pop
);
  import dtpv_pkg::*;

  class_t                cls_in;
  logic [$bits(class_t)-1:0] cls_vec;
  logic                  q_empty;

  always_comb begin
    cls_in.is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
    cls_in.is_dash  = (item.char_code == CHAR_DASH);
    cls_in.digit    = item.char_code[3:0];
    cls_in.is_last  = item.is_last;
  end

  dtpv_fifo #(
    .WIDTH($bits(class_t)),
    .DEPTH(DEPTH)
  ) u_char_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cls_in),
    .full    (full),
    .rd_en   (cls_pop),
    .rd_data (cls_vec),
    .empty   (q_empty)
  );

  assign cls       = class_t'(cls_vec);
  assign cls_valid = !q_empty;

endmodule

FILE: src/dtpv_back.sv
// Back end: per-character field accumulation and end-of-string snapshot.
`timescale 1ns / 1ps

module dtpv_back (
  input  logic             clk,
  input  logic             rst,
  input  dtpv_pkg::class_t cls,
  input  logic             cls_valid,
  output logic             cls_pop,
  input  logic             snap_take,
  output dtpv_pkg::snap_t  snap,
  output logic             snap_valid
);
  import dtpv_pkg::*;

  logic [3:0]       pos, pos_next;
  logic [7:0]       head, head_next;
  logic [1:0]       fidx, fidx_next;
  logic [2:0][30:0] vals, vals_next;
  logic [2:0]       ovf, ovf_next;
  logic [2:0]       nonempty, nonempty_next;
  logic [2:0]       nondig, nondig_next;
  logic [8:0]       ymod_lead, ymod_lead_next;
  logic [8:0]       ymod_tail, ymod_tail_next;

  logic [34:0] prod;
  logic [11:0] ymx, ysub;
  logic [8:0]  ym_cur, ym_new;
  logic        accept;
  snap_t       snap_next;

  // A last character needs the snapshot slot free (or draining this cycle)
  assign accept  = cls_valid && (!cls.is_last || !snap_valid || snap_take);
  assign cls_pop = accept;

  // value * 10 + digit on the field being filled
  always_comb begin
    prod = ({4'b0, vals[fidx]} << 3) + ({4'b0, vals[fidx]} << 1) + {31'b0, cls.digit};
  end

  // running year value mod 400: x < 4000, so at most nine steps of 400 to remove
  always_comb begin
    ym_cur = (fidx == 2'd0) ? ymod_lead : ymod_tail;
    ymx    = ({3'b0, ym_cur} << 3) + ({3'b0, ym_cur} << 1) + {8'b0, cls.digit};
    ysub   = '0;
    for (int k = 1; k <= 9; k++) begin
      if (ymx >= 12'(k * YEAR_MOD)) ysub = 12'(k * YEAR_MOD);
    end
    ym_new = 9'(ymx - ysub);
  end

  always_comb begin
    head_next      = head;
    pos_next       = (pos < 4'(HEAD_LEN)) ? pos + 1'b1 : pos;
    fidx_next      = fidx;
    vals_next      = vals;
    ovf_next       = ovf;
    nonempty_next  = nonempty;
    nondig_next    = nondig;
    ymod_lead_next = ymod_lead;
    ymod_tail_next = ymod_tail;

    case (pos)
      4'd0:    if (cls.is_digit) head_next[HF_C0_DIGIT] = 1'b1;
      4'd1:    if (cls.is_digit) head_next[HF_C1_DIGIT] = 1'b1;
      4'd2:    if (cls.is_dash)  head_next[HF_C2_DASH]  = 1'b1;
      4'd3:    if (cls.is_digit) head_next[HF_C3_DIGIT] = 1'b1;
      4'd4: begin
        if (cls.is_digit) head_next[HF_C4_DIGIT] = 1'b1;
        if (cls.is_dash)  head_next[HF_C4_DASH]  = 1'b1;
      end
      4'd5:    if (cls.is_dash)  head_next[HF_C5_DASH]  = 1'b1;
      4'd7:    if (cls.is_dash)  head_next[HF_C7_DASH]  = 1'b1;
      default: ;
    endcase

    if (cls.is_dash && (fidx < 2'd2)) begin
      fidx_next = fidx + 1'b1;
    end else begin
      nonempty_next[fidx] = 1'b1;
      if (!cls.is_digit) begin
        nondig_next[fidx] = 1'b1;
      end else begin
        if (prod > {4'b0, VAL_MAX}) begin
          ovf_next[fidx]  = 1'b1;
          vals_next[fidx] = VAL_MAX;
        end else begin
          vals_next[fidx] = prod[30:0];
        end
        if (fidx == 2'd0) ymod_lead_next = ym_new;
        else if (fidx == 2'd2) ymod_tail_next = ym_new;
      end
    end

    snap_next.pos_full  = (pos_next >= 4'(HEAD_LEN));
    snap_next.head      = head_next;
    snap_next.nonempty  = nonempty_next;
    snap_next.nondig    = nondig_next;
    snap_next.ovf       = ovf_next;
    snap_next.vals      = vals_next;
    snap_next.ymod_lead = ymod_lead_next;
    snap_next.ymod_tail = ymod_tail_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && cls.is_last)) begin
      pos       <= '0;
      head      <= '0;
      fidx      <= '0;
      vals      <= '0;
      ovf       <= '0;
      nonempty  <= '0;
      nondig    <= '0;
      ymod_lead <= '0;
      ymod_tail <= '0;
    end else if (accept) begin
      pos       <= pos_next;
      head      <= head_next;
      fidx      <= fidx_next;
      vals      <= vals_next;
      ovf       <= ovf_next;
      nonempty  <= nonempty_next;
      nondig    <= nondig_next;
      ymod_lead <= ymod_lead_next;
      ymod_tail <= ymod_tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && cls.is_last) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cls.is_last) snap <= snap_next;
  end

endmodule

FILE: src/dtpv_check.sv
// Format detection and calendar check on a finished string snapshot.
`timescale 1ns / 1ps

module dtpv_check (
  input  dtpv_pkg::snap_t   snap,
  output dtpv_pkg::result_t res
);
  import dtpv_pkg::*;

  fmt_t        fmt;
  logic        fields_ok, leap, ok;
  logic [30:0] d, m, y;
  logic [8:0]  ymod;
  logic [4:0]  lim;

  always_comb begin
    fmt = FMT_NONE;
    if (snap.pos_full) begin
      if (snap.head[HF_C0_DIGIT] && snap.head[HF_C4_DASH] && snap.head[HF_C7_DASH]) begin
        fmt = FMT_YMD;
      end else if (snap.head[5:0] == 6'h3F) begin
        // both leading pairs are plain two-digit numbers here
        if ((snap.vals[0] > 31'(MONTHS)) && (snap.vals[1] <= 31'(MONTHS))) fmt = FMT_DMY;
        else fmt = FMT_MDY;
      end
    end

    fields_ok = (fmt != FMT_NONE) && (snap.nonempty == 3'b111) &&
                (snap.nondig == 3'b000) && (snap.ovf == 3'b000);

    case (fmt)
      FMT_YMD: begin
        y = snap.vals[0]; m = snap.vals[1]; d = snap.vals[2]; ymod = snap.ymod_lead;
      end
      FMT_MDY: begin
        m = snap.vals[0]; d = snap.vals[1]; y = snap.vals[2]; ymod = snap.ymod_tail;
      end
      default: begin
        d = snap.vals[0]; m = snap.vals[1]; y = snap.vals[2]; ymod = snap.ymod_tail;
      end
    endcase

    // ymod < 400: century years other than the 400th are common years
    leap = (ymod[1:0] == 2'b00) && (ymod != 9'(CENTURY)) &&
           (ymod != 9'(2 * CENTURY)) && (ymod != 9'(3 * CENTURY));
    lim  = ((m == 31'(MONTH_FEB)) && leap) ? 5'(LEAP_FEB_DAYS) : month_days(m[3:0]);
    ok   = fields_ok && (m >= 31'd1) && (m <= 31'(MONTHS)) && (d >= 31'd1) &&
           (d <= {26'b0, lim});

    res.date_valid  = ok;
    res.format_code = fmt;
    res.day_out     = ok ? d[4:0] : '0;
    res.month_out   = ok ? m[3:0] : '0;
    res.year_out    = ok ? y : '0;
  end

endmodule
